[rtl/huffman_code_bit_packer_assert.svh]
// assertion macros for the code packer
`ifndef HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH
`ifndef SYNTH
`define HCBP_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("assertion failed");
`define HCBP_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("assertion failed");
`else
`define HCBP_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define HCBP_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

[rtl/hcbp_pkg.sv]
`timescale 1ns / 1ps
package hcbp_pkg;

	localparam int MAX_CODE_LEN_DEF = 30;
	localparam int SYMBOL_COUNT_DEF = 256;
	localparam int CODE_FIELD_W     = 30;
	localparam int LEN_FIELD_W      = 5;
	localparam int SYM_FIELD_W      = 8;
	localparam int BYTE_W           = 8;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_ENCODE = 2'd1;
	localparam logic [1:0] CMD_FLUSH  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOOK = 4'b0010,
		ST_EMIT = 4'b0100,
		ST_ERR  = 4'b1000
	} state_t;

endpackage

[rtl/huffman_code_bit_packer.sv]
`timescale 1ns / 1ps
// Huffman code bit packer.
// Input channel (in_valid/in_ready) takes commands: load writes one symbol's
// code and length into the code table, encode appends a symbol's code to the
// MSB-first output byte stream, flush emits the pending partial byte padded
// with zeros. Output channel (out_valid/out_ready) carries out_byte, status
// (1 for an unmapped symbol) and last on the final result of each command.
// Steps: a load only writes the table entry. An encode issues the table
// read, then does the registered read and bit alignment, then emits its
// output bytes (up to 4) one byte per cycle through the output register
// while the receiver does not stall. A flush with bits pending sends its
// padded byte through the same emit step.
// Reset clears the pending bits and the per-entry valid bits at once, so every
// symbol reads as unmapped; no clearing pass is needed.
// When the receiver stalls, the output register holds its result; the block
// still takes the next command, and stalls only once a new result is ready.
module huffman_code_bit_packer #(
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
	parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           command,
	input  logic [hcbp_pkg::SYM_FIELD_W-1:0]     symbol,
	input  logic [hcbp_pkg::CODE_FIELD_W-1:0]    code_bits,
	input  logic [hcbp_pkg::LEN_FIELD_W-1:0]     code_length,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [hcbp_pkg::BYTE_W-1:0]          out_byte,
	output logic                                 status,
	output logic                                 last
);

	localparam int CODE_W = (MAX_CODE_LEN < hcbp_pkg::CODE_FIELD_W) ?
		MAX_CODE_LEN : hcbp_pkg::CODE_FIELD_W;
	localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
	localparam int SYM_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int ENT_W  = CODE_W + LEN_W;
	localparam int ACC_W  = hcbp_pkg::BYTE_W + MAX_CODE_LEN;
	localparam int TOT_W  = $clog2(MAX_CODE_LEN + 2 * hcbp_pkg::BYTE_W);
	localparam int CMP_W  = hcbp_pkg::LEN_FIELD_W + 1;

	hcbp_pkg::state_t state_q;

	logic [ENT_W-1:0]              mem_q [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0]       valid_q;
	logic [ENT_W-1:0]              rd_s1;
	logic                          valid_s1;
	logic                          range_s1;

	logic [hcbp_pkg::BYTE_W-1:0]   pending_byte_q;
	logic [2:0]                    pending_count_q;
	logic [ACC_W-1:0]              acc_q;
	logic [TOT_W-1:0]              total_q;

	logic                          out_valid_q;
	logic [hcbp_pkg::BYTE_W-1:0]   out_byte_q;
	logic                          status_q;
	logic                          last_q;

	logic                          in_xfer;
	logic                          out_free;
	logic                          out_load;
	logic [SYM_W-1:0]              sym_idx;
	logic                          sym_in_range;
	logic [CMP_W-1:0]              len_sat;
	logic [CODE_W-1:0]             cw_s1;
	logic [LEN_W-1:0]              len_s1;
	logic [MAX_CODE_LEN-1:0]       cw_ext;
	logic [MAX_CODE_LEN-1:0]       rev;
	logic [ACC_W-1:0]              code_al;
	logic [ACC_W-1:0]              acc_n;
	logic [TOT_W-1:0]              total_n;
	logic                          mapped_s1;
	logic                          emit_last;

	assign in_ready     = (state_q == hcbp_pkg::ST_IDLE);
	assign in_xfer      = in_valid & in_ready;
	assign out_free     = ~out_valid_q | out_ready;
	assign out_load     = out_free &
		((state_q == hcbp_pkg::ST_EMIT) | (state_q == hcbp_pkg::ST_ERR));
	assign sym_idx      = symbol[SYM_W-1:0];
	assign sym_in_range = ({1'b0, symbol} < (hcbp_pkg::SYM_FIELD_W + 1)'(SYMBOL_COUNT));

	always_comb begin
		if ({1'b0, code_length} > CMP_W'(MAX_CODE_LEN)) begin
			len_sat = CMP_W'(MAX_CODE_LEN);
		end else begin
			len_sat = {1'b0, code_length};
		end
	end

	// code table
	always_ff @(posedge clk) begin
		if (in_xfer && command == hcbp_pkg::CMD_LOAD && sym_in_range) begin
			mem_q[sym_idx] <= {code_bits[CODE_W-1:0], len_sat[LEN_W-1:0]};
		end
		if (in_xfer) begin
			rd_s1    <= mem_q[sym_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			valid_s1 <= 1'b0;
			range_s1 <= 1'b0;
		end else if (in_xfer) begin
			if (command == hcbp_pkg::CMD_LOAD && sym_in_range) begin
				valid_q[sym_idx] <= 1'b1;
			end
			valid_s1 <= valid_q[sym_idx];
			range_s1 <= sym_in_range;
		end
	end

	assign cw_s1     = rd_s1[ENT_W-1 -: CODE_W];
	assign len_s1    = rd_s1[LEN_W-1:0];
	assign mapped_s1 = range_s1 & valid_s1 & (len_s1 != '0);
	assign cw_ext    = MAX_CODE_LEN'(cw_s1);

	// first code bit goes to the top, bits past the length are dropped
	always_comb begin
		for (int i = 0; i < MAX_CODE_LEN; i++) begin
			rev[MAX_CODE_LEN-1-i] = cw_ext[i] & (i < int'(len_s1));
		end
	end

	assign code_al   = {rev, {hcbp_pkg::BYTE_W{1'b0}}} >> pending_count_q;
	assign acc_n     = {pending_byte_q, {MAX_CODE_LEN{1'b0}}} | code_al;
	assign total_n   = TOT_W'(pending_count_q) + TOT_W'(len_s1);
	assign emit_last = (total_q < TOT_W'(2 * hcbp_pkg::BYTE_W));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= hcbp_pkg::ST_IDLE;
			pending_byte_q  <= '0;
			pending_count_q <= '0;
			acc_q           <= '0;
			total_q         <= '0;
			out_valid_q     <= 1'b0;
			out_byte_q      <= '0;
			status_q        <= 1'b0;
			last_q          <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				hcbp_pkg::ST_IDLE: begin
					if (in_xfer) begin
						case (command)
							hcbp_pkg::CMD_ENCODE: begin
								state_q <= hcbp_pkg::ST_LOOK;
							end
							hcbp_pkg::CMD_FLUSH: begin
								if (pending_count_q != '0) begin
									acc_q   <= {pending_byte_q, {MAX_CODE_LEN{1'b0}}};
									total_q <= TOT_W'(hcbp_pkg::BYTE_W);
									state_q <= hcbp_pkg::ST_EMIT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				hcbp_pkg::ST_LOOK: begin
					if (!mapped_s1) begin
						state_q <= hcbp_pkg::ST_ERR;
					end else if (total_n >= TOT_W'(hcbp_pkg::BYTE_W)) begin
						acc_q   <= acc_n;
						total_q <= total_n;
						state_q <= hcbp_pkg::ST_EMIT;
					end else begin
						pending_byte_q  <= acc_n[ACC_W-1 -: hcbp_pkg::BYTE_W];
						pending_count_q <= total_n[2:0];
						state_q         <= hcbp_pkg::ST_IDLE;
					end
				end
				hcbp_pkg::ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= acc_q[ACC_W-1 -: hcbp_pkg::BYTE_W];
						status_q    <= 1'b0;
						last_q      <= emit_last;
						acc_q       <= acc_q << hcbp_pkg::BYTE_W;
						total_q     <= total_q - TOT_W'(hcbp_pkg::BYTE_W);
						if (emit_last) begin
							pending_byte_q  <= acc_q[ACC_W-hcbp_pkg::BYTE_W-1 -: hcbp_pkg::BYTE_W];
							pending_count_q <= total_q[2:0];
							state_q         <= hcbp_pkg::ST_IDLE;
						end
					end
				end
				hcbp_pkg::ST_ERR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= '0;
						status_q    <= 1'b1;
						last_q      <= 1'b1;
						state_q     <= hcbp_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= hcbp_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign status    = status_q;
	assign last      = last_q;

`include "huffman_code_bit_packer_assert.svh"

	`HCBP_ASSERT_IMPLY(a_emit_total, clk, arst_n, state_q == hcbp_pkg::ST_EMIT, total_q >= TOT_W'(hcbp_pkg::BYTE_W))
	`HCBP_ASSERT_IMPLY(a_err_last, clk, arst_n, out_valid_q && status_q, last_q && out_byte_q == '0)
	`HCBP_ASSERT_NEXT(a_encode_look, clk, arst_n, in_xfer && command == hcbp_pkg::CMD_ENCODE, state_q == hcbp_pkg::ST_LOOK)
	`HCBP_ASSERT_NEXT(a_look_once, clk, arst_n, state_q == hcbp_pkg::ST_LOOK, state_q != hcbp_pkg::ST_LOOK)

endmodule
